/* rtl/sdd_pkg.sv */
// ----------------------------------------------------------------------------
// sdd_pkg: shared types and constants of the sse data-line deframer
// character codes, line phase codes, result bundle and queue sizing
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_T     = 8'h74;

  // line phase codes
  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_MATCH1  = 4'd1;
  localparam logic [3:0] PH_MATCH4  = 4'd4;
  localparam logic [3:0] PH_COLON   = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_IGNORE  = 4'd7;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // transaction ops
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] cnt;
    logic       kind0;
    logic [7:0] val0;
    logic       kind1;
    logic [7:0] val1;
  } res_bundle_t;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_req;
  } item_t;

  // expected character of "data:" at a given match position
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_D;
      3'd1:    c = CH_A;
      3'd2:    c = CH_T;
      3'd3:    c = CH_A;
      3'd4:    c = CH_COLON;
      default: c = CH_COLON;
    endcase
    return c;
  endfunction

endpackage

/* rtl/sdd_parse.sv */
// ----------------------------------------------------------------------------
// sdd_parse: line state machine of the deframer
// holds line phase, held cr and event flags; emits up to two results per byte
// ----------------------------------------------------------------------------
module sdd_parse import sdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_vld,
  input  item_t       item,
  output res_bundle_t res
);

  logic [3:0] phase_r, phase_nxt;
  logic       cr_r, cr_nxt;
  logic       ehd_r, ehd_nxt;

  always_comb begin
    logic [7:0] b;
    b         = item.byte_req;
    phase_nxt = phase_r;
    cr_nxt    = cr_r;
    ehd_nxt   = ehd_r;
    res       = '0;

    if (item_vld) begin
      if (item.op == OP_FLUSH) begin
        if (ehd_r) begin
          res.cnt   = 2'd1;
          res.kind0 = KIND_MARKER;
        end
        phase_nxt = PH_START;
        cr_nxt    = 1'b0;
        ehd_nxt   = 1'b0;
      end else if (phase_r == PH_START) begin
        if (b == CH_LF) begin
          // blank line, with or without a held cr
          if (ehd_r) begin
            res.cnt   = 2'd1;
            res.kind0 = KIND_MARKER;
          end
          ehd_nxt = 1'b0;
          cr_nxt  = 1'b0;
        end else if (cr_r) begin
          cr_nxt    = 1'b0;
          phase_nxt = PH_IGNORE;
        end else if (b == CH_CR) begin
          cr_nxt = 1'b1;
        end else if (b == prefix_char(3'd0)) begin
          phase_nxt = PH_MATCH1;
        end else begin
          phase_nxt = PH_IGNORE;
        end
      end else if (phase_r >= PH_MATCH1 && phase_r <= PH_MATCH4) begin
        if (b == CH_LF) begin
          phase_nxt = PH_START;
          cr_nxt    = 1'b0;
        end else if (b == prefix_char(phase_r[2:0])) begin
          phase_nxt = phase_r + 4'd1;
          if (phase_r == PH_MATCH4) begin
            // joining newline ahead of a second data line
            if (ehd_r) begin
              res.cnt  = 2'd1;
              res.val0 = CH_LF;
            end
            ehd_nxt = 1'b1;
          end
        end else begin
          phase_nxt = PH_IGNORE;
        end
      end else if (phase_r == PH_COLON) begin
        if (b == CH_LF) begin
          phase_nxt = PH_START;
          cr_nxt    = 1'b0;
        end else if (b == CH_SPACE) begin
          phase_nxt = PH_PAYLOAD;
        end else if (b == CH_CR) begin
          cr_nxt    = 1'b1;
          phase_nxt = PH_PAYLOAD;
        end else begin
          res.cnt   = 2'd1;
          res.val0  = b;
          phase_nxt = PH_PAYLOAD;
        end
      end else if (phase_r == PH_PAYLOAD) begin
        if (b == CH_LF) begin
          phase_nxt = PH_START;
          cr_nxt    = 1'b0;
        end else if (cr_r) begin
          // held cr was not a line end
          res.val0 = CH_CR;
          if (b == CH_CR) begin
            res.cnt = 2'd1;
          end else begin
            res.cnt  = 2'd2;
            res.val1 = b;
            cr_nxt   = 1'b0;
          end
        end else if (b == CH_CR) begin
          cr_nxt = 1'b1;
        end else begin
          res.cnt  = 2'd1;
          res.val0 = b;
        end
      end else begin
        if (b == CH_LF) begin
          phase_nxt = PH_START;
        end
        cr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      cr_r    <= 1'b0;
      ehd_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cr_r    <= cr_nxt;
      ehd_r   <= ehd_nxt;
    end
  end

endmodule

/* rtl/sdd_outq.sv */
// ----------------------------------------------------------------------------
// sdd_outq: result queue of the deframer
// takes up to two results per cycle, hands out one per transaction
// ----------------------------------------------------------------------------
module sdd_outq import sdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  res_bundle_t res,
  output logic        room,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_value,
  output logic        out_last
);

  logic             kind_r [QDEPTH];
  logic [7:0]       val_r  [QDEPTH];
  logic             last_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             pop;
  logic [QAW-1:0]   wr_ptr1;

  assign room      = (cnt_r <= QCW'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign wr_ptr1   = wr_ptr_r + QAW'(1);

  assign out_kind  = kind_r[rd_ptr_r];
  assign out_value = val_r[rd_ptr_r];
  assign out_last  = last_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(res.cnt);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
    cnt_nxt    = cnt_r + QCW'(res.cnt) - QCW'(pop);
  end

  // payload entries
  always_ff @(posedge clk) begin
    if (res.cnt != 2'd0) begin
      kind_r[wr_ptr_r] <= res.kind0;
      val_r[wr_ptr_r]  <= res.val0;
      last_r[wr_ptr_r] <= (res.cnt == 2'd1);
    end
    if (res.cnt == 2'd2) begin
      kind_r[wr_ptr1] <= res.kind1;
      val_r[wr_ptr1]  <= res.val1;
      last_r[wr_ptr1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/sse_data_line_deframer_top.sv */
// path: an accepted byte waits in the input register until the queue has room, then
//   the combinational parser writes its results into the queue that drives the port
// throughput: one transaction per cycle while not stalled; a byte that gives two
//   results (held cr then a payload byte) takes two output transactions, absorbed by the result queue
// in_stall rises only while the input register waits for two free queue slots
// reset: synchronous active-low rst_n empties the input register and queue and
//   puts the line state at line start with no held cr and no pending event
// ----------------------------------------------------------------------------
// sse_data_line_deframer_top: server-sent-events data-line deframer
// streams payload bytes of data: lines and emits event-complete markers
// ----------------------------------------------------------------------------
module sse_data_line_deframer_top import sdd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_byte_req,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);

  // input register: one transaction held for the parser
  logic        in_vld_r, in_vld_nxt;
  item_t       item_r;
  logic        room;
  logic        adv;
  res_bundle_t res;

  // the held transaction moves on when the queue can take two results
  assign adv      = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  // register stays full while stalled, otherwise it reloads from the port
  assign in_vld_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // payload loads on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.op       <= in_op;
      item_r.byte_req <= in_byte_req;
    end
  end

  // line state machine, one byte per cycle while the queue has room
  sdd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (adv),
    .item     (item_r),
    .res      (res)
  );

  // result queue, also the output register
  sdd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

/* rtl/sdd_checker.sv */
// ----------------------------------------------------------------------------
// sdd_checker: port-level checks of the deframer
// result handshake, marker form and reset state
// ----------------------------------------------------------------------------
module sdd_checker import sdd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_op,
  input logic [7:0] in_byte_req,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_value,
  input logic       out_last
);

  // a stalled input transaction stays offered with the same payload
  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_op) && $stable(in_byte_req))
    else $error("input transaction changed while stalled");

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_kind) && $stable(out_value) && $stable(out_last))
    else $error("result payload changed while stalled");

  // a marker always stands alone and carries no byte
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_MARKER) |-> out_last && (out_value == 8'd0))
    else $error("malformed event-complete marker");

  // reset empties the pipeline
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not idle after reset");

endmodule

bind sse_data_line_deframer_top sdd_checker u_sdd_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sse data-line deframer
// a directed table and then random server-sent-event lines go through the
// valid/stall input port; a behavioral deframer predicts every payload byte
// and event marker, and results are compared field by field in order
// ----------------------------------------------------------------------------
module tb_top;
  import sdd_pkg::*;

  // run sizing
  localparam int          N_DIRECTED   = 28;
  localparam int          RANDOM_ITEMS = 620;
  localparam int          FEED_MAX     = N_DIRECTED + RANDOM_ITEMS + 64;
  localparam int          WANT_MAX     = 2 * FEED_MAX;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 20;

  // "data:" as the line prefix that opens a payload line
  localparam logic [7:0] DATA_TAG [5] = '{CH_D, CH_A, CH_T, CH_A, CH_COLON};

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } deframe_res_t;

  // one input transaction, optionally with its results typed in by hand
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    logic [1:0] nres;
    logic       k0;
    logic [7:0] v0;
    logic       k1;
    logic [7:0] v1;
  } feed_row_t;

  // directed part: extremes, held cr cases, joining newline on an empty data
  // line, flush with an unfinished line, crlf blank line, cr-led ignored line
  localparam feed_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_BYTE,  CH_D,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_A,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_T,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_A,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_COLON, 1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_SPACE, 1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  8'hFF,    1'b1, 2'd1, KIND_BYTE,   8'hFF, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_CR,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  8'h00,    1'b1, 2'd2, KIND_BYTE,   CH_CR, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_CR,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_LF,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_D,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_A,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_T,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_A,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_COLON, 1'b1, 2'd1, KIND_BYTE,   CH_LF, KIND_BYTE, 8'h00},
    '{OP_FLUSH, 8'hFF,    1'b1, 2'd1, KIND_MARKER, 8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_D,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_A,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_T,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_A,     1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_COLON, 1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_LF,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_CR,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_LF,    1'b1, 2'd1, KIND_MARKER, 8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_CR,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  8'h7A,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00},
    '{OP_BYTE,  CH_LF,    1'b0, 2'd0, KIND_BYTE,   8'h00, KIND_BYTE, 8'h00}
  };

  // clock and dut ports, the bench-driven ones known from time zero
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_op       = OP_BYTE;
  logic [7:0] in_byte_req = 8'h00;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_value;
  logic       out_last;

  // stimulus list and scoreboard
  feed_row_t    feed_mem [FEED_MAX];
  int           feed_len = 0;
  deframe_res_t want_mem [WANT_MAX];
  int           want_wr  = 0;
  int           want_rd  = 0;
  deframe_res_t step_res [2];
  int           step_cnt = 0;
  int           acc_count  = 0;
  int           fail_count = 0;

  // mirror of the deframer line state
  logic [3:0] pr_phase = PH_START;
  logic       pr_cr    = 1'b0;
  logic       pr_evt   = 1'b0;

  always #6 clk = ~clk;

  sse_data_line_deframer_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_byte_req (in_byte_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .out_last    (out_last)
  );

  // ---------------------------------------------------------------------------
  // behavioral deframer: one transaction in, its results left in step_res
  // ---------------------------------------------------------------------------
  task automatic emit(input logic kind, input logic [7:0] value);
    step_res[step_cnt] = deframe_res_t'{kind, value, 1'b0};
    step_cnt = step_cnt + 1;
  endtask

  task automatic deframe_step(input logic op, input logic [7:0] b);
    step_cnt = 0;
    if (op == OP_FLUSH) begin
      // end of stream drops a held cr and closes the event
      if (pr_evt) emit(KIND_MARKER, 8'h00);
      pr_phase = PH_START;
      pr_cr    = 1'b0;
      pr_evt   = 1'b0;
    end else if (pr_phase == PH_START) begin
      if (pr_cr) begin
        if (b == CH_LF) begin
          // crlf blank line
          if (pr_evt) emit(KIND_MARKER, 8'h00);
          pr_evt = 1'b0;
          pr_cr  = 1'b0;
        end else begin
          // lone cr at line start makes a non-blank ignored line
          pr_cr    = 1'b0;
          pr_phase = PH_IGNORE;
        end
      end else if (b == CH_LF) begin
        if (pr_evt) emit(KIND_MARKER, 8'h00);
        pr_evt = 1'b0;
      end else if (b == CH_CR) begin
        pr_cr = 1'b1;
      end else if (b == DATA_TAG[0]) begin
        pr_phase = PH_MATCH1;
      end else begin
        pr_phase = PH_IGNORE;
      end
    end else if (pr_phase >= PH_MATCH1 && pr_phase <= PH_MATCH4) begin
      if (b == CH_LF) begin
        pr_phase = PH_START;
        pr_cr    = 1'b0;
      end else if (b == DATA_TAG[pr_phase[2:0]]) begin
        pr_phase = pr_phase + 4'd1;
        if (pr_phase == PH_COLON) begin
          // a second data line of the event is joined by a newline
          if (pr_evt) emit(KIND_BYTE, CH_LF);
          pr_evt = 1'b1;
        end
      end else begin
        pr_phase = PH_IGNORE;
      end
    end else if (pr_phase == PH_COLON) begin
      if (b == CH_LF) begin
        pr_phase = PH_START;
        pr_cr    = 1'b0;
      end else if (b == CH_SPACE) begin
        pr_phase = PH_PAYLOAD;
      end else if (b == CH_CR) begin
        pr_cr    = 1'b1;
        pr_phase = PH_PAYLOAD;
      end else begin
        emit(KIND_BYTE, b);
        pr_phase = PH_PAYLOAD;
      end
    end else if (pr_phase == PH_PAYLOAD) begin
      if (b == CH_LF) begin
        pr_phase = PH_START;
        pr_cr    = 1'b0;
      end else begin
        // a held cr not followed by lf is payload
        if (pr_cr) begin
          emit(KIND_BYTE, CH_CR);
          pr_cr = 1'b0;
        end
        if (b == CH_CR) pr_cr = 1'b1;
        else emit(KIND_BYTE, b);
      end
    end else begin
      // ignored line, including unused phase codes
      if (b == CH_LF) begin
        pr_phase = PH_START;
        pr_cr    = 1'b0;
      end else begin
        pr_cr = 1'b0;
      end
    end
    if (step_cnt > 0) step_res[step_cnt - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic feed_add(input feed_row_t row);
    feed_mem[feed_len] = row;
    feed_len = feed_len + 1;
  endtask

  task automatic want_add(input deframe_res_t r);
    want_mem[want_wr] = r;
    want_wr = want_wr + 1;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    feed_add(feed_row_t'{OP_BYTE, b, 1'b0, 2'd0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00});
  endtask

  task automatic queue_flush();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    feed_add(feed_row_t'{OP_FLUSH, junk, 1'b0, 2'd0, KIND_BYTE, 8'h00,
                         KIND_BYTE, 8'h00});
  endtask

  // lf or crlf
  task automatic queue_eol();
    if ($urandom_range(0, 1) == 1) queue_byte(CH_CR);
    queue_byte(CH_LF);
  endtask

  function automatic logic [7:0] pick_payload();
    if ($urandom_range(0, 99) < 12) return CH_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed event lines with random content, some noise
  task automatic queue_random_line();
    int unsigned sel;
    int unsigned len;
    int unsigned tail;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      for (int i = 0; i < 5; i++) queue_byte(DATA_TAG[i]);
      if ($urandom_range(0, 9) < 7) queue_byte(CH_SPACE);
      len = $urandom_range(0, 6);
      for (int i = 0; i < int'(len); i++) queue_byte(pick_payload());
      tail = $urandom_range(0, 9);
      if (tail < 8) queue_eol();
      else if (tail == 9) queue_flush();
      // event boundary now and then
      if ($urandom_range(0, 99) < 35) queue_eol();
    end else if (sel < 68) begin
      queue_eol();
    end else if (sel < 75) begin
      // comment line
      queue_byte(CH_COLON);
      len = $urandom_range(0, 5);
      for (int i = 0; i < int'(len); i++) queue_byte(8'($urandom_range(0, 255)));
      queue_eol();
    end else if (sel < 82) begin
      // broken prefix
      len = $urandom_range(1, 4);
      for (int i = 0; i < int'(len); i++) queue_byte(DATA_TAG[i]);
      if ($urandom_range(0, 1) == 1) queue_byte(8'($urandom_range(0, 255)));
      queue_eol();
    end else if (sel < 88) begin
      // other field line
      len = $urandom_range(1, 6);
      for (int i = 0; i < int'(len); i++) queue_byte(8'($urandom_range(0, 255)));
      queue_eol();
    end else if (sel < 93) begin
      queue_flush();
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < int'(len); i++) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: holds a stalled transaction, idles at random between items
  // ---------------------------------------------------------------------------
  int          feed_idx = 0;
  int unsigned in_gap   = 0;
  int unsigned in_calm  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) feed_idx = feed_idx + 1;
      if (in_valid && in_stall) begin
        // stalled payload stays put
      end else if (in_gap > 0) begin
        in_gap   = in_gap - 1;
        in_valid <= 1'b0;
      end else if (feed_idx < feed_len) begin
        in_valid    <= 1'b1;
        in_op       <= feed_mem[feed_idx].op;
        in_byte_req <= feed_mem[feed_idx].data;
        // gap after this item; calm stretches send back to back
        if (in_calm > 0) begin
          in_calm = in_calm - 1;
          in_gap  = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          in_calm = 40;
          in_gap  = 0;
        end else begin
          in_gap = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stall, calm stretches, one long hold-off so the
  // block fills its result queue and pushes back on the input
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned out_calm   = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && acc_count >= 300) begin
      hold_done = 1'b1;
      hold_left = 250;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall  <= 1'b1;
    end else if (out_calm > 0) begin
      out_calm  = out_calm - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      out_calm  = 60;
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_stall  <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check the accepted result against the oldest expectation, then
  // predict the results of an input transaction accepted at this edge
  // ---------------------------------------------------------------------------
  deframe_res_t want;
  feed_row_t    took;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (want_rd == want_wr) begin
          $error("result with nothing expected: kind %0d value %02h last %0d",
                 out_kind, out_value, out_last);
          fail_count++;
        end else begin
          want    = want_mem[want_rd];
          want_rd = want_rd + 1;
          if (out_kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_value !== want.value) begin
            $error("value mismatch: expected %02h, actual %02h", want.value, out_value);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        took = feed_mem[acc_count];
        deframe_step(took.op, took.data);
        if (took.typed) begin
          // hand-written results; the predictor state still moves on
          if (took.nres >= 2'd1)
            want_add(deframe_res_t'{took.k0, took.v0, took.nres == 2'd1});
          if (took.nres == 2'd2)
            want_add(deframe_res_t'{took.k1, took.v1, 1'b1});
        end else begin
          for (int i = 0; i < step_cnt; i++) want_add(step_res[i]);
        end
        acc_count <= acc_count + 1;
      end
    end
  end

  // watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: build stimulus, reset, wait for drain, report
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < N_DIRECTED; i++) feed_add(DIRECTED[i]);
    while (feed_len < N_DIRECTED + RANDOM_ITEMS) queue_random_line();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (acc_count == feed_len && want_rd == want_wr);
    // extra results would show up here
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sdd_pkg.sv
rtl/sdd_parse.sv
rtl/sdd_outq.sv
rtl/sse_data_line_deframer_top.sv
rtl/sdd_checker.sv
tb/tb_top.sv
